// ----- hw/rtl/lrucb_pkg.sv -----
// Package for the LRU byte-budget table: sizes, codes, entry and cell control types.
// No dependencies; used by the interfaces, the cell and the top level.
package lrucb_pkg;

	localparam int NUM_ENTRIES = 64;
	localparam int KEY_W       = 64;
	localparam int LEN_W       = 32;
	localparam int TIME_W      = 48;
	localparam int HANDLE_W    = 32;
	localparam int BUDGET_W    = 38;
	localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
	localparam int SUM_W       = LEN_W + $clog2(NUM_ENTRIES);
	localparam int OUT_CNT_W   = 7;

	localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(134217728);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] RES_DONE    = 2'd0;
	localparam logic [1:0] RES_MISS    = 2'd1;
	localparam logic [1:0] RES_EXPIRED = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [LEN_W-1:0]    len;
		logic [TIME_W-1:0]   expiry;
		logic [HANDLE_W-1:0] handle;
	} slot_t;

	typedef struct packed {
		logic  valid;
		slot_t data;
	} entry_t;

	typedef enum logic [2:0] {
		OP_HOLD   = 3'd0,
		OP_SEARCH = 3'd1,
		OP_REMOVE = 3'd2,
		OP_PUSH   = 3'd3,
		OP_FRONT  = 3'd4,
		OP_EVICT  = 3'd5
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [KEY_W-1:0] key;
	} cell_ctl_t;

	// count / 10 by reciprocal multiply, exact for counts below 1024
	function automatic logic [CNT_W-1:0] div10(input logic [CNT_W-1:0] c);
		logic [CNT_W+7:0] p;
		p = (CNT_W+8)'(c) * (CNT_W+8)'(205);
		return CNT_W'(p >> 11);
	endfunction

endpackage

// ----- hw/rtl/lrucb_if.sv -----
// Handshake channels of the LRU byte-budget table: request, response and budget write.
// Depends on lrucb_pkg for field widths.
interface lrucb_req_if import lrucb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          cmd;
	logic [KEY_W-1:0]    key;
	logic [LEN_W-1:0]    entry_length;
	logic [TIME_W-1:0]   expire_time;
	logic [HANDLE_W-1:0] value_handle;
	logic [TIME_W-1:0]   now_time;
	modport source (output valid, cmd, key, entry_length, expire_time, value_handle, now_time,
		input ready);
	modport sink (input valid, cmd, key, entry_length, expire_time, value_handle, now_time,
		output ready);
endinterface

interface lrucb_rsp_if import lrucb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           outcome;
	logic [HANDLE_W-1:0]  hit_handle;
	logic [OUT_CNT_W-1:0] evicted_count;
	logic [OUT_CNT_W-1:0] entry_count;
	logic [BUDGET_W-1:0]  total_length;
	modport source (output valid, outcome, hit_handle, evicted_count, entry_count, total_length,
		input ready);
	modport sink (input valid, outcome, hit_handle, evicted_count, entry_count, total_length,
		output ready);
endinterface

interface lrucb_cfg_if import lrucb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BUDGET_W-1:0] max_total_length;
	modport source (output valid, max_total_length, input ready);
	modport sink (input valid, max_total_length, output ready);
endinterface

// ----- hw/rtl/lrucb_cell.sv -----
// One slot of the recency chain: holds an entry and moves it to or from its neighbours.
// Depends on lrucb_pkg.
module lrucb_cell import lrucb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    prev_entry,
	input  entry_t    next_entry,
	input  logic      seen_in,
	output entry_t    entry,
	output logic      hit,
	output logic      seen_out,
	output logic      is_last
);

	logic  valid_q;
	logic  hit_q;
	slot_t data_q;

	assign entry    = '{valid: valid_q, data: data_q};
	assign hit      = hit_q;
	assign seen_out = seen_in | hit_q;
	assign is_last  = valid_q & ~next_entry.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			case (ctl.op)
				OP_SEARCH: hit_q <= valid_q && (data_q.key == ctl.key);
				OP_REMOVE: if (seen_out) valid_q <= next_entry.valid;
				OP_PUSH:   valid_q <= prev_entry.valid;
				OP_FRONT:  if (!seen_in) valid_q <= prev_entry.valid;
				OP_EVICT:  if (is_last) valid_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_REMOVE: if (seen_out) data_q <= next_entry.data;
			OP_PUSH:   data_q <= prev_entry.data;
			OP_FRONT:  if (!seen_in) data_q <= prev_entry.data;
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/lru_cache_byte_budget.sv -----
// Top level of the LRU byte-budget table: chain of entry cells and the operation sequencer.
// Depends on lrucb_pkg, lrucb_if and lrucb_cell.
//
// Entries sit in a row of 64 cells ordered by recency, cell 0 the most recent, valid cells
// packed at the front. All cells compare the key at once, and removal, insertion and
// move-to-front are shifts of the whole row. A request is searched and captured, then
// removes, evicts, pushes or moves to the front as its command needs; an insert then checks
// the budget in rounds, each evicting up to a tenth of the entries (at least one); the
// sequencer handles one request at a time, taking the next while the prior result waits.
module lru_cache_byte_budget import lrucb_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	lrucb_req_if.sink    req,
	lrucb_rsp_if.source  rsp,
	lrucb_cfg_if.sink    cfg
);

	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_SEARCH  = 10'b0000000010,
		S_CAPTURE = 10'b0000000100,
		S_REMOVE  = 10'b0000001000,
		S_FULL    = 10'b0000010000,
		S_PUSH    = 10'b0000100000,
		S_BCHECK  = 10'b0001000000,
		S_BEVICT  = 10'b0010000000,
		S_FRONT   = 10'b0100000000,
		S_DONE    = 10'b1000000000
	} state_t;

	state_t                state_q;
	logic [BUDGET_W-1:0]   budget_q;
	logic [1:0]            cmd_q;
	logic [KEY_W-1:0]      key_q;
	logic [LEN_W-1:0]      len_q;
	logic [TIME_W-1:0]     expiry_q;
	logic [HANDLE_W-1:0]   handle_q;
	logic [TIME_W-1:0]     now_q;
	slot_t                 sel_q;
	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      batch_q;
	logic [OUT_CNT_W-1:0]  evicted_q;
	logic [1:0]            outcome_q;
	logic [HANDLE_W-1:0]   hit_handle_q;
	logic                  rsp_valid_q;
	logic [1:0]            rsp_outcome_q;
	logic [HANDLE_W-1:0]   rsp_handle_q;
	logic [OUT_CNT_W-1:0]  rsp_evicted_q;
	logic [OUT_CNT_W-1:0]  rsp_count_q;
	logic [BUDGET_W-1:0]   rsp_total_q;

	cell_ctl_t             ctl;
	entry_t                head;
	entry_t                cell_e   [NUM_ENTRIES];
	entry_t                prev_e   [NUM_ENTRIES];
	entry_t                next_e   [NUM_ENTRIES];
	logic [NUM_ENTRIES:0]  seen;
	logic [NUM_ENTRIES-1:0] hit_vec;
	logic [NUM_ENTRIES-1:0] last_vec;
	slot_t                 sel_d;
	logic [LEN_W-1:0]      last_len;
	logic                  any_hit;
	logic [CNT_W-1:0]      batch_d;
	logic                  rsp_load;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid         = rsp_valid_q;
	assign rsp.outcome       = rsp_outcome_q;
	assign rsp.hit_handle    = rsp_handle_q;
	assign rsp.evicted_count = rsp_evicted_q;
	assign rsp.entry_count   = rsp_count_q;
	assign rsp.total_length  = rsp_total_q;

	// load the result register once it is empty or being drained
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// cell row
	assign seen[0] = 1'b0;

	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			prev_e[i] = (i == 0) ? head : cell_e[(i == 0) ? 0 : i - 1];
			next_e[i] = (i == NUM_ENTRIES - 1) ? entry_t'('0)
				: cell_e[(i == NUM_ENTRIES - 1) ? i : i + 1];
		end
	end

	for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
		lrucb_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_entry (prev_e[g]),
			.next_entry (next_e[g]),
			.seen_in    (seen[g]),
			.entry      (cell_e[g]),
			.hit        (hit_vec[g]),
			.seen_out   (seen[g+1]),
			.is_last    (last_vec[g])
		);
	end

	// pick the matching entry and the length of the oldest one
	always_comb begin
		sel_d    = '0;
		last_len = '0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			sel_d    = slot_t'(sel_d | (cell_e[i].data & {$bits(slot_t){hit_vec[i]}}));
			last_len = last_len | (cell_e[i].data.len & {LEN_W{last_vec[i]}});
		end
	end

	assign any_hit = |hit_vec;
	assign batch_d = (div10(count_q) == '0) ? CNT_W'(1) : div10(count_q);

	always_comb begin
		ctl.key = key_q;
		ctl.op  = OP_HOLD;
		head    = '{valid: 1'b1, data: sel_q};
		unique case (state_q)
			S_SEARCH: ctl.op = OP_SEARCH;
			S_REMOVE: ctl.op = OP_REMOVE;
			S_FULL:   ctl.op = OP_EVICT;
			S_BEVICT: ctl.op = OP_EVICT;
			S_PUSH: begin
				ctl.op = OP_PUSH;
				head   = '{valid: 1'b1, data: '{key: key_q, len: len_q, expiry: expiry_q,
					handle: handle_q}};
			end
			S_FRONT:  ctl.op = OP_FRONT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
		end else if (cfg.valid) begin
			budget_q <= cfg.max_total_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) state_q <= S_SEARCH;
				end
				S_SEARCH: state_q <= S_CAPTURE;
				S_CAPTURE: begin
					case (cmd_q)
						CMD_INSERT: begin
							if (any_hit) state_q <= S_REMOVE;
							else if (count_q == CNT_W'(NUM_ENTRIES)) state_q <= S_FULL;
							else state_q <= S_PUSH;
						end
						CMD_LOOKUP: begin
							if (!any_hit) state_q <= S_DONE;
							else if (now_q >= sel_d.expiry) state_q <= S_REMOVE;
							else state_q <= S_FRONT;
						end
						CMD_REMOVE: state_q <= any_hit ? S_REMOVE : S_DONE;
						default: state_q <= S_DONE;
					endcase
				end
				S_REMOVE: begin
					sum_q   <= sum_q - SUM_W'(sel_q.len);
					count_q <= count_q - 1'b1;
					state_q <= (cmd_q == CMD_INSERT) ? S_PUSH : S_DONE;
				end
				S_FULL: begin
					sum_q   <= sum_q - SUM_W'(last_len);
					count_q <= count_q - 1'b1;
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					sum_q   <= sum_q + SUM_W'(len_q);
					count_q <= count_q + 1'b1;
					state_q <= S_BCHECK;
				end
				S_BCHECK: begin
					if (sum_q > SUM_W'(budget_q) && count_q != '0) state_q <= S_BEVICT;
					else state_q <= S_DONE;
				end
				S_BEVICT: begin
					sum_q   <= sum_q - SUM_W'(last_len);
					count_q <= count_q - 1'b1;
					// end the round when the batch or the table runs out
					if (batch_q == CNT_W'(1) || count_q == CNT_W'(1)) state_q <= S_BCHECK;
				end
				S_FRONT: state_q <= S_DONE;
				S_DONE: begin
					if (rsp_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q        <= req.cmd;
				key_q        <= req.key;
				len_q        <= req.entry_length;
				expiry_q     <= req.expire_time;
				handle_q     <= req.value_handle;
				now_q        <= req.now_time;
				evicted_q    <= '0;
				outcome_q    <= RES_DONE;
				hit_handle_q <= '0;
			end
			S_CAPTURE: begin
				sel_q <= sel_d;
				if (!any_hit && (cmd_q == CMD_LOOKUP || cmd_q == CMD_REMOVE))
					outcome_q <= RES_MISS;
				else if (cmd_q == CMD_LOOKUP && now_q >= sel_d.expiry)
					outcome_q <= RES_EXPIRED;
			end
			S_FULL: evicted_q <= evicted_q + 1'b1;
			S_BCHECK: batch_q <= batch_d;
			S_BEVICT: begin
				evicted_q <= evicted_q + 1'b1;
				batch_q   <= batch_q - 1'b1;
			end
			S_FRONT: hit_handle_q <= sel_q.handle;
			S_DONE: begin
				if (rsp_load) begin
					rsp_outcome_q <= outcome_q;
					rsp_handle_q  <= hit_handle_q;
					rsp_evicted_q <= evicted_q;
					rsp_count_q   <= OUT_CNT_W'(count_q);
					rsp_total_q   <= BUDGET_W'(sum_q);
				end
			end
			default: ;
		endcase
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_ENTRIES))
		else $error("entry count above table size");

	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(last_vec))
		else $error("more than one oldest cell");

	a_evict_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BEVICT || state_q == S_FULL) |-> (count_q != '0 && last_vec != '0))
		else $error("eviction from an empty table");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUSH |=> (count_q != '0 && cell_e[0].valid))
		else $error("insert left the front cell empty");

endmodule
